/* src/ynmf_pkg.sv */
package ynmf_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int HEIGHT_LIMIT  = 4094;
    localparam int Q_DEPTH       = 2;

    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_RECT_LEFT    = 3'd2;
    localparam logic [2:0] REG_RECT_RIGHT   = 3'd3;
    localparam logic [2:0] REG_RECT_TOP     = 3'd4;
    localparam logic [2:0] REG_RECT_BOTTOM  = 3'd5;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_luma_a;
        logic [7:0] in_chroma_u;
        logic [7:0] in_luma_b;
        logic [7:0] in_chroma_v;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_luma_a;
        logic [7:0] out_chroma_u;
        logic [7:0] out_luma_b;
        logic [7:0] out_chroma_v;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [11:0] rect_left;
        logic [11:0] rect_right;
        logic [11:0] rect_top;
        logic [11:0] rect_bottom;
    } cfg_t;

    // per component neighbor sums, lane 0 = Y0 ... lane 3 = V
    typedef struct packed {
        logic [3:0][10:0] sum;
        logic [3:0]       count;
        logic [31:0]      center;
        logic             filt;
        logic             frame_end;
    } q_entry_t;

    // ceil(2^16 / c); exact floor division for sums below 2048
    function automatic logic [16:0] recip(input logic [3:0] c);
        logic [16:0] r;
        case (c)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

/* src/ynmf_front.sv */
module ynmf_front #(
    parameter int MAX_WIDTH = ynmf_pkg::DEF_MAX_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ynmf_pkg::cfg_t     cfg,
    input  logic               push,
    output logic               full,
    input  ynmf_pkg::in_item_t in_data,
    input  logic               q_full,
    output logic               q_push,
    output ynmf_pkg::q_entry_t q_data
);
    import ynmf_pkg::*;

    localparam int LW     = MAX_WIDTH / 2;
    localparam int ADDR_W = $clog2(LW);
    localparam int COL_W  = ADDR_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [COL_W-1:0] col_reg;
    logic [11:0]      row_reg;
    logic [31:0]      win_reg [9];
    logic [31:0]      upper_mem [LW];
    logic [31:0]      middle_mem [LW];
    logic [31:0]      up_rd_reg, mid_rd_reg, pix_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic             emit_reg, rect_reg, up_ok_reg, dn_ok_reg, lf_ok_reg, rt_ok_reg, fe_reg;

    logic [13:0]      mw, m14, h14, bot14;
    logic [COL_W-1:0] m, col_n, ecol;
    logic [11:0]      h, row_n, erow;
    logic             accept, wrap, emit, drain_skip;
    logic [13:0]      x14;

    always_comb
    begin
        mw = {3'd0, cfg.frame_width[11:1]};
        if (mw == 14'd0)
            m14 = 14'd1;
        else if (mw > 14'(LW))
            m14 = 14'(LW);
        else
            m14 = mw;
        m = m14[COL_W-1:0];
        h14 = {2'd0, cfg.frame_height};
        if (h14 == 14'd0)
            h14 = 14'd1;
        else if (h14 > 14'(HEIGHT_LIMIT))
            h14 = 14'(HEIGHT_LIMIT);
        h = h14[11:0];
        bot14 = ({2'd0, cfg.rect_bottom} < h14) ? {2'd0, cfg.rect_bottom} : h14;

        wrap = (14'(col_reg) >= m14) || (14'(row_reg) > h14 + 14'd1)
            || (14'(row_reg) == h14 + 14'd1 && col_reg != '0);
        col_n = wrap ? '0 : col_reg;
        row_n = wrap ? '0 : row_reg;

        accept = push && !full;
        drain_skip = in_data.kind && (row_n < h);

        if (col_n == '0)
        begin
            emit = row_n >= 12'd2;
            erow = row_n - 12'd2;
            ecol = m - COL_W'(1);
        end
        else
        begin
            emit = row_n >= 12'd1;
            erow = row_n - 12'd1;
            ecol = col_n - COL_W'(1);
        end
        x14 = {13'(ecol), 1'b0};
    end

    assign full = (state_reg != ST_IDLE) || q_full;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && !drain_skip) state_next = ST_READ;
            ST_READ: state_next = ST_SUM;
            ST_SUM:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (drain_skip)
                begin
                    col_reg <= col_n;
                    row_reg <= row_n;
                end
                else if (14'(row_n) == h14 + 14'd1)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (14'(col_n) + 14'd1 >= m14)
                begin
                    col_reg <= '0;
                    row_reg <= row_n + 12'd1;
                end
                else
                begin
                    col_reg <= col_n + COL_W'(1);
                    row_reg <= row_n;
                end
            end
            if (state_reg == ST_READ)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= up_rd_reg;
                win_reg[5] <= mid_rd_reg;
                win_reg[8] <= pix_reg;
            end
        end
    end

    // item bookkeeping, line store reads and line store writes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg   <= col_n[ADDR_W-1:0];
            up_rd_reg  <= upper_mem[col_n[ADDR_W-1:0]];
            mid_rd_reg <= middle_mem[col_n[ADDR_W-1:0]];
            pix_reg    <= (row_n < h) ? {in_data.in_chroma_v, in_data.in_luma_b,
                                         in_data.in_chroma_u, in_data.in_luma_a} : '0;
            emit_reg   <= emit;
            rect_reg   <= ({2'd0, erow} >= {2'd0, cfg.rect_top}) && ({2'd0, erow} < bot14)
                       && (x14 >= {2'd0, cfg.rect_left}) && (x14 < {2'd0, cfg.rect_right});
            up_ok_reg  <= erow >= 12'd1;
            dn_ok_reg  <= 14'(erow) + 14'd1 < h14;
            lf_ok_reg  <= ecol != '0;
            rt_ok_reg  <= 14'(ecol) + 14'd1 < m14;
            fe_reg     <= (erow == h - 12'd1) && (ecol == m - COL_W'(1));
        end
        if (state_reg == ST_READ)
        begin
            upper_mem[addr_reg]  <= mid_rd_reg;
            middle_mem[addr_reg] <= pix_reg;
        end
    end

    // neighbor sums from the centered window (center in column 1)
    always_comb
    begin
        logic rok, cok;
        q_data = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rok = (r == 0) ? up_ok_reg : ((r == 2) ? dn_ok_reg : 1'b1);
                cok = (c == 0) ? lf_ok_reg : ((c == 2) ? rt_ok_reg : 1'b1);
                if (rok && cok && !(r == 1 && c == 1))
                begin
                    for (int q = 0; q < 4; q++)
                        q_data.sum[q] = q_data.sum[q] + 11'(win_reg[r*3+c][q*8 +: 8]);
                    q_data.count = q_data.count + 4'd1;
                end
            end
        end
        q_data.center    = win_reg[4];
        q_data.filt      = rect_reg && (q_data.count != 4'd0);
        q_data.frame_end = fe_reg;
    end

    assign q_push = (state_reg == ST_SUM) && emit_reg;

endmodule

/* src/ynmf_queue.sv */
module ynmf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  ynmf_pkg::q_entry_t wr_data,
    input  logic               rd,
    output ynmf_pkg::q_entry_t rd_data,
    output logic [1:0]         count,
    output logic               q_full,
    output logic               q_empty
);
    import ynmf_pkg::*;

    q_entry_t mem_reg [Q_DEPTH];
    logic     wp_reg, rp_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            count_reg <= count_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rp_reg];
    assign count   = count_reg;
    assign q_full  = count_reg == 2'(Q_DEPTH);
    assign q_empty = count_reg == 2'd0;

endmodule

/* src/ynmf_back.sv */
module ynmf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  ynmf_pkg::q_entry_t  q_data,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output ynmf_pkg::out_item_t out_data
);
    import ynmf_pkg::*;

    logic        out_valid_reg;
    out_item_t   out_reg;
    logic [16:0] rc;
    logic [27:0] prod [4];
    logic [3:0][7:0] res;

    assign q_pop = !q_empty && (!out_valid_reg || pop);

    always_comb
    begin
        rc = recip(q_data.count);
        for (int q = 0; q < 4; q++)
        begin
            prod[q] = 28'(q_data.sum[q]) * 28'(rc);
            res[q]  = q_data.filt ? prod[q][23:16] : q_data.center[q*8 +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (q_pop)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_reg <= '{out_luma_a: res[0], out_chroma_u: res[1], out_luma_b: res[2],
                         out_chroma_v: res[3], frame_end: q_data.frame_end};
    end

    assign empty    = !out_valid_reg;
    assign out_data = out_reg;

endmodule

/* src/yuy2_neighbor_mean_filter_core.sv */
// Channel   Handshake        Payload
// input     push / full      in_data   (kind, Y0, U, Y1, V)
// result    pop / empty      out_data  (Y0, U, Y1, V, frame_end)
// config    cfg_we           cfg_index, cfg_data
//
// Front end handles each item in turn: accept, line store read, window sum, then idle again.
// A drain beat that is ignored inside the frame skips the line store read and window sum.
// Back end registers the neighbor mean (reciprocal multiply) or the unfiltered center.
// Results lag one line plus one macropixel; a 2-entry queue sits between front and back.
// Reset clears position, window and queues; line stores are not cleared.
// full rises while the front end works on a beat or the queue is full.
module yuy2_neighbor_mean_filter_core #(
    parameter int MAX_WIDTH = ynmf_pkg::DEF_MAX_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ynmf_pkg::in_item_t  in_data,
    output logic                empty,
    input  logic                pop,
    output ynmf_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [11:0]         cfg_data
);
    import ynmf_pkg::*;

    cfg_t     cfg_reg;
    q_entry_t fq_data, bq_data;
    logic     q_push, q_pop, q_full, q_empty;
    logic [1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{frame_width: 12'd640, frame_height: 12'd480, rect_left: 12'd0,
                         rect_right: 12'd2048, rect_top: 12'd0, rect_bottom: 12'd2048};
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data;
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                REG_RECT_LEFT:    cfg_reg.rect_left    <= cfg_data;
                REG_RECT_RIGHT:   cfg_reg.rect_right   <= cfg_data;
                REG_RECT_TOP:     cfg_reg.rect_top     <= cfg_data;
                REG_RECT_BOTTOM:  cfg_reg.rect_bottom  <= cfg_data;
                default: ;
            endcase
        end
    end

    ynmf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .push(push), .full(full),
        .in_data(in_data), .q_full(q_full), .q_push(q_push), .q_data(fq_data)
    );

    ynmf_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(q_push), .wr_data(fq_data), .rd(q_pop),
        .rd_data(bq_data), .count(q_count), .q_full(q_full), .q_empty(q_empty)
    );

    ynmf_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(bq_data), .q_pop(q_pop),
        .empty(empty), .pop(pop), .out_data(out_data)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count != 2'(Q_DEPTH) || q_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_count != 2'd0) else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= 2'(Q_DEPTH)) else $error("queue count out of range");
    a_busy_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !empty) else $error("result lost after queue pop");

endmodule
